[rtl/core/exp_taylor_series_core_defines.svh]
// ---------------------------------------------------------------------------
// exp_taylor_series_core assertion macros
// concurrent checks, compiled out for synthesis
// ---------------------------------------------------------------------------
`ifndef EXP_TAYLOR_SERIES_CORE_DEFINES_SVH
`define EXP_TAYLOR_SERIES_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// check held off while reset is asserted
`define ETS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("exp core assertion failed");
// check that also holds during reset
`define ETS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("exp core assertion failed");
`else
`define ETS_ASSERT(lbl, clk, rst_n, prop)
`define ETS_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

[rtl/core/exp_ts_pkg.sv]
// ---------------------------------------------------------------------------
// exp_ts_pkg
// shared types and constants for the taylor series exponential core
// ---------------------------------------------------------------------------
`default_nettype none

package exp_ts_pkg;

  localparam int MAX_TERMS_DEF = 40;

  localparam int X_W     = 16;   // q4.12 exponent
  localparam int XMAG_W  = 16;   // |x| up to 8.0
  localparam int X_FRAC  = 12;
  localparam int EXP_W   = 32;   // q12.20 result
  localparam int TERMS_W = 6;
  localparam int TOL_W   = 20;
  localparam int MAG_W   = 32;   // term magnitude, q.20
  localparam int PROD_W  = 2 * MAG_W;
  localparam int SUM_W   = MAG_W + 2;

  localparam logic [TOL_W-1:0]   TOL_RST   = TOL_W'(1);
  localparam logic [MAG_W-1:0]   Q20_ONE   = MAG_W'(1) << 20;
  localparam logic [TERMS_W-1:0] TERMS_SAT = {TERMS_W{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_X,
    ST_MUL_R,
    ST_MUL_I,
    ST_UPD,
    ST_DONE
  } ets_state_t;

  // operand pairs for the shared multiplier
  typedef enum logic [1:0] {
    MOP_X,   // magnitude * |x|
    MOP_R,   // quotient estimate: (product >> 12) * reciprocal
    MOP_I    // back-multiply: estimate * index
  } mul_op_t;

  typedef struct packed {
    logic in_fire;
    logic term_stop;
    logic out_free;
  } seq_stat_t;

  typedef struct packed {
    logic    in_ready;
    logic    mul_en;
    mul_op_t mul_op;
    logic    upd_en;
    logic    out_load;
  } seq_ctrl_t;

endpackage

`default_nettype wire

[rtl/core/exp_taylor_series_core.sv]
// after input accept, each of n terms (1..MAX_TERMS) runs ST_MUL_X, ST_MUL_R, ST_MUL_I
//   and ST_UPD: three passes through the single shared 32x32 multiplier (|x| product,
//   reciprocal estimate, back-multiply) and one step to correct and accumulate; then
//   ST_DONE loads the result when the output is free; a new input waits for ST_IDLE
// reset: rst_n synchronous active low; returns to idle, drops out_valid and sets the
//   tolerance register to 1 (q0.20)
// ---------------------------------------------------------------------------
// exp_taylor_series_core
// e^x by taylor series: signed q4.12 in, unsigned q12.20 out
// ---------------------------------------------------------------------------
`default_nettype none
`include "exp_taylor_series_core_defines.svh"

module exp_taylor_series_core #(
  parameter int MAX_TERMS = exp_ts_pkg::MAX_TERMS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output      logic                                 in_ready,
  input  wire logic signed [exp_ts_pkg::X_W-1:0]    in_x_value,
  output      logic                                 out_valid,
  input  wire logic                                 out_ready,
  output      logic [exp_ts_pkg::EXP_W-1:0]         out_exp_value,
  output      logic [exp_ts_pkg::TERMS_W-1:0]       out_terms_used,
  output      logic                                 out_limit_hit,
  input  wire logic                                 cfg_wr_en,
  input  wire logic [exp_ts_pkg::TOL_W-1:0]         cfg_wr_data
);

  localparam int IDX_W = $clog2(MAX_TERMS + 1);
  localparam int MAG_W = exp_ts_pkg::MAG_W;
  localparam int SUM_W = exp_ts_pkg::SUM_W;
  localparam int EXP_W = exp_ts_pkg::EXP_W;
  localparam int CW    = IDX_W + 1;   // room for the terms clamp compare
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_TERMS);
  localparam logic [exp_ts_pkg::TERMS_W-1:0] TERMS_MAX =
    (MAX_TERMS > 63) ? exp_ts_pkg::TERMS_SAT : exp_ts_pkg::TERMS_W'(MAX_TERMS);

  exp_ts_pkg::seq_stat_t stat;
  exp_ts_pkg::seq_ctrl_t ctrl;

  logic [exp_ts_pkg::TOL_W-1:0]  tol_r;
  logic                          x_neg_r;
  logic [exp_ts_pkg::XMAG_W-1:0] xmag_r;
  logic [MAG_W-1:0]              mag_r;
  logic                          tneg_r;
  logic signed [SUM_W-1:0]       sum_r;
  logic [IDX_W-1:0]              idx_r;
  logic [MAG_W-1:0]              quo_r;
  logic [MAG_W-1:0]              est_r;
  logic                          lim_r;

  logic [exp_ts_pkg::XMAG_W-1:0] xmag_in;
  logic [exp_ts_pkg::PROD_W-1:0] prod_r;
  logic [MAG_W-1:0]              recip;
  logic [MAG_W-1:0]              quo;
  logic [MAG_W-1:0]              est;
  logic [MAG_W-1:0]              rem;
  logic [MAG_W-1:0]              mag_new;
  logic                          tneg_new;
  logic signed [SUM_W-1:0]       sum_new;
  logic                          below_tol;

  logic                          out_valid_r;
  logic [EXP_W-1:0]              out_exp_r;
  logic [exp_ts_pkg::TERMS_W-1:0] out_terms_r;
  logic                          out_lim_r;
  logic [EXP_W-1:0]              exp_clamp;
  logic [exp_ts_pkg::TERMS_W-1:0] terms_clamp;
  logic [CW-1:0]                 idx_ext;

  exp_ts_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  exp_ts_recip #(.MAX_TERMS(MAX_TERMS)) u_recip (
    .idx   (idx_r),
    .recip (recip)
  );

  exp_ts_mul #(.MAX_TERMS(MAX_TERMS)) u_mul (
    .clk    (clk),
    .en     (ctrl.mul_en),
    .op     (ctrl.mul_op),
    .mag    (mag_r),
    .xmag   (xmag_r),
    .quo    (quo),
    .recip  (recip),
    .est    (est),
    .idx    (idx_r),
    .prod_r (prod_r)
  );

  assign in_ready       = ctrl.in_ready;
  assign stat.in_fire   = in_valid && ctrl.in_ready;
  assign stat.out_free  = !out_valid_r || out_ready;
  assign stat.term_stop = below_tol || (idx_r == IDX_LAST);

  // two's complement magnitude, -8.0 gives 0x8000
  assign xmag_in = in_x_value[exp_ts_pkg::X_W-1] ? (~in_x_value + 1'b1) : in_x_value;

  // floor(prod / 4096), then floor(quo / i) via reciprocal and one correction
  assign quo = prod_r[exp_ts_pkg::X_FRAC +: MAG_W];
  assign est = prod_r[exp_ts_pkg::PROD_W-1 -: MAG_W];
  assign rem = quo_r - prod_r[MAG_W-1:0];
  assign mag_new  = est_r + MAG_W'(rem >= MAG_W'(idx_r));
  assign tneg_new = tneg_r ^ x_neg_r;
  assign sum_new  = tneg_new ? (sum_r - $signed({2'b00, mag_new}))
                             : (sum_r + $signed({2'b00, mag_new}));
  assign below_tol = mag_new < MAG_W'(tol_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= exp_ts_pkg::TOL_RST;
    end else if (cfg_wr_en) begin
      tol_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.in_fire) begin
      x_neg_r <= in_x_value[exp_ts_pkg::X_W-1];
      xmag_r  <= xmag_in;
      mag_r   <= exp_ts_pkg::Q20_ONE;
      tneg_r  <= 1'b0;
      sum_r   <= $signed({2'b00, exp_ts_pkg::Q20_ONE});
      idx_r   <= IDX_W'(1);
    end else if (ctrl.upd_en) begin
      mag_r  <= mag_new;
      tneg_r <= tneg_new;
      sum_r  <= sum_new;
      lim_r  <= !below_tol;
      if (!stat.term_stop) idx_r <= idx_r + IDX_W'(1);
    end
    if (ctrl.mul_en && ctrl.mul_op == exp_ts_pkg::MOP_R) quo_r <= quo;
    if (ctrl.mul_en && ctrl.mul_op == exp_ts_pkg::MOP_I) est_r <= est;
  end

  // negative sum clamps to zero, too large saturates
  always_comb begin
    priority if (sum_r[SUM_W-1]) begin
      exp_clamp = '0;
    end else if (|sum_r[SUM_W-2:EXP_W]) begin
      exp_clamp = '1;
    end else begin
      exp_clamp = sum_r[EXP_W-1:0];
    end
  end

  assign idx_ext     = CW'(idx_r);
  assign terms_clamp = (idx_ext > CW'(exp_ts_pkg::TERMS_SAT)) ? exp_ts_pkg::TERMS_SAT
                                                             : exp_ts_pkg::TERMS_W'(idx_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      out_exp_r   <= exp_clamp;
      out_terms_r <= terms_clamp;
      out_lim_r   <= lim_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_exp_value  = out_exp_r;
  assign out_terms_used = out_terms_r;
  assign out_limit_hit  = out_lim_r;

  `ETS_ASSERT(a_idx_in_range, clk, rst_n, (ctrl.mul_en || ctrl.upd_en) |-> (idx_r != '0 && idx_r <= IDX_LAST))
  `ETS_ASSERT(a_rem_bounded, clk, rst_n, ctrl.upd_en |-> rem < (MAG_W'(idx_r) << 1))
  `ETS_ASSERT(a_limit_terms, clk, rst_n, (out_valid_r && out_lim_r) |-> out_terms_r == TERMS_MAX)

endmodule

`default_nettype wire

[rtl/core/exp_ts_recip.sv]
// ---------------------------------------------------------------------------
// exp_ts_recip
// constant table of floor((2^32 - 1) / i) for term index i
// ---------------------------------------------------------------------------
`default_nettype none

module exp_ts_recip #(
  parameter int MAX_TERMS = exp_ts_pkg::MAX_TERMS_DEF,
  localparam int IDX_W    = $clog2(MAX_TERMS + 1)
) (
  input  wire logic [IDX_W-1:0]               idx,
  output      logic [exp_ts_pkg::MAG_W-1:0]   recip
);

  localparam int AW = $clog2(MAX_TERMS);

  logic [exp_ts_pkg::MAG_W-1:0] tbl [MAX_TERMS];
  logic [IDX_W-1:0]             addr_full;

  for (genvar g = 0; g < MAX_TERMS; g++) begin : g_tbl
    localparam logic [exp_ts_pkg::MAG_W-1:0] RV =
      {exp_ts_pkg::MAG_W{1'b1}} / exp_ts_pkg::MAG_W'(g + 1);
    assign tbl[g] = RV;
  end

  // index runs from one
  assign addr_full = idx - IDX_W'(1);
  assign recip     = tbl[addr_full[AW-1:0]];

endmodule

`default_nettype wire

[rtl/core/exp_ts_mul.sv]
// ---------------------------------------------------------------------------
// exp_ts_mul
// shared 32x32 multiplier with operand select and registered product
// ---------------------------------------------------------------------------
`default_nettype none

module exp_ts_mul #(
  parameter int MAX_TERMS = exp_ts_pkg::MAX_TERMS_DEF,
  localparam int IDX_W    = $clog2(MAX_TERMS + 1)
) (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire exp_ts_pkg::mul_op_t               op,
  input  wire logic [exp_ts_pkg::MAG_W-1:0]      mag,
  input  wire logic [exp_ts_pkg::XMAG_W-1:0]     xmag,
  input  wire logic [exp_ts_pkg::MAG_W-1:0]      quo,
  input  wire logic [exp_ts_pkg::MAG_W-1:0]      recip,
  input  wire logic [exp_ts_pkg::MAG_W-1:0]      est,
  input  wire logic [IDX_W-1:0]                  idx,
  output      logic [exp_ts_pkg::PROD_W-1:0]     prod_r
);

  logic [exp_ts_pkg::MAG_W-1:0]  opa;
  logic [exp_ts_pkg::MAG_W-1:0]  opb;
  logic [exp_ts_pkg::PROD_W-1:0] prod_nxt;

  always_comb begin
    unique case (op)
      exp_ts_pkg::MOP_X: begin
        opa = mag;
        opb = exp_ts_pkg::MAG_W'(xmag);
      end
      exp_ts_pkg::MOP_R: begin
        opa = quo;
        opb = recip;
      end
      exp_ts_pkg::MOP_I: begin
        opa = est;
        opb = exp_ts_pkg::MAG_W'(idx);
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  assign prod_nxt = exp_ts_pkg::PROD_W'(opa) * exp_ts_pkg::PROD_W'(opb);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/core/exp_ts_seq.sv]
// ---------------------------------------------------------------------------
// exp_ts_seq
// sequencer: three multiplier phases and an update per term, then result hand-off
// ---------------------------------------------------------------------------
`default_nettype none
`include "exp_taylor_series_core_defines.svh"

module exp_ts_seq (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire exp_ts_pkg::seq_stat_t  stat,
  output      exp_ts_pkg::seq_ctrl_t  ctrl
);

  exp_ts_pkg::ets_state_t state_r;
  exp_ts_pkg::ets_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= exp_ts_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      exp_ts_pkg::ST_IDLE: begin
        if (stat.in_fire) state_nxt = exp_ts_pkg::ST_MUL_X;
      end
      exp_ts_pkg::ST_MUL_X: state_nxt = exp_ts_pkg::ST_MUL_R;
      exp_ts_pkg::ST_MUL_R: state_nxt = exp_ts_pkg::ST_MUL_I;
      exp_ts_pkg::ST_MUL_I: state_nxt = exp_ts_pkg::ST_UPD;
      exp_ts_pkg::ST_UPD: begin
        state_nxt = stat.term_stop ? exp_ts_pkg::ST_DONE : exp_ts_pkg::ST_MUL_X;
      end
      exp_ts_pkg::ST_DONE: begin
        if (stat.out_free) state_nxt = exp_ts_pkg::ST_IDLE;
      end
      default: state_nxt = exp_ts_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl          = '0;
    ctrl.mul_op   = exp_ts_pkg::MOP_X;
    unique case (state_r)
      exp_ts_pkg::ST_IDLE:  ctrl.in_ready = 1'b1;
      exp_ts_pkg::ST_MUL_X: begin
        ctrl.mul_en = 1'b1;
        ctrl.mul_op = exp_ts_pkg::MOP_X;
      end
      exp_ts_pkg::ST_MUL_R: begin
        ctrl.mul_en = 1'b1;
        ctrl.mul_op = exp_ts_pkg::MOP_R;
      end
      exp_ts_pkg::ST_MUL_I: begin
        ctrl.mul_en = 1'b1;
        ctrl.mul_op = exp_ts_pkg::MOP_I;
      end
      exp_ts_pkg::ST_UPD:   ctrl.upd_en   = 1'b1;
      exp_ts_pkg::ST_DONE:  ctrl.out_load = stat.out_free;
      default: ;
    endcase
  end

  `ETS_ASSERT(a_accept_starts, clk, rst_n, stat.in_fire |=> state_r == exp_ts_pkg::ST_MUL_X)
  `ETS_ASSERT(a_next_term, clk, rst_n, (state_r == exp_ts_pkg::ST_UPD && !stat.term_stop) |=> state_r == exp_ts_pkg::ST_MUL_X)
  `ETS_ASSERT(a_done_waits, clk, rst_n, (state_r == exp_ts_pkg::ST_DONE && !stat.out_free) |=> state_r == exp_ts_pkg::ST_DONE)

endmodule

`default_nettype wire

[sim/tb_exp_taylor_series_core.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_exp_taylor_series_core
// feeds q4.12 exponents through the core under several tolerance settings,
// predicts each e^x result, term count and limit flag, or takes a typed one,
// and compares in order; both channels idle at random save in one phase
// ---------------------------------------------------------------------------

module tb_exp_taylor_series_core;

  localparam int X_W     = exp_ts_pkg::X_W;
  localparam int EXP_W   = exp_ts_pkg::EXP_W;
  localparam int TERMS_W = exp_ts_pkg::TERMS_W;
  localparam int TOL_W   = exp_ts_pkg::TOL_W;
  localparam logic [TOL_W-1:0] TOL_RST = exp_ts_pkg::TOL_RST;

  localparam int TERM_LIMIT  = exp_ts_pkg::MAX_TERMS_DEF;
  localparam int QUIET_LIMIT = 5000;
  localparam int N_DIR       = 23;
  localparam int N_PHASE     = 8;
  localparam int PHASE_ITEMS = 106;

  typedef struct packed {
    logic [EXP_W-1:0]   exp_value;
    logic [TERMS_W-1:0] terms_used;
    logic               limit_hit;
  } exp_res_t;

  typedef struct packed {
    logic [TOL_W-1:0] tol;
    logic [X_W-1:0]   x;
    logic             typed;
    exp_res_t         res;
  } dir_row_t;

  // directed rows; a result is typed in only where it is obvious
  localparam dir_row_t DIR_TAB [N_DIR] = '{
    '{20'h00001, 16'h0000, 1'b1, '{32'h0010_0000, 6'd1, 1'b0}},
    '{20'h00001, 16'h7FFF, 1'b0, '0},
    '{20'h00001, 16'h8000, 1'b0, '0},
    '{20'h00001, 16'h0001, 1'b0, '0},
    '{20'h00001, 16'hFFFF, 1'b0, '0},
    '{20'h00001, 16'h1000, 1'b0, '0},
    '{20'h00001, 16'hF000, 1'b0, '0},
    '{20'h00001, 16'h5555, 1'b0, '0},
    '{20'h00001, 16'hAAAA, 1'b0, '0},
    '{20'h00000, 16'h0000, 1'b1, '{32'h0010_0000, 6'(TERM_LIMIT), 1'b1}},
    '{20'h00000, 16'h7FFF, 1'b0, '0},
    '{20'h00000, 16'h8000, 1'b0, '0},
    '{20'h00000, 16'h1000, 1'b0, '0},
    '{20'hFFFFF, 16'h0000, 1'b1, '{32'h0010_0000, 6'd1, 1'b0}},
    '{20'hFFFFF, 16'h0001, 1'b1, '{32'h0010_0100, 6'd1, 1'b0}},
    '{20'hFFFFF, 16'hFFFF, 1'b1, '{32'h000F_FF00, 6'd1, 1'b0}},
    '{20'hFFFFF, 16'h8000, 1'b0, '0},
    '{20'hFFFFF, 16'h7FFF, 1'b0, '0},
    '{20'hFFFFF, 16'h9000, 1'b0, '0},
    '{20'hFFFFF, 16'hA000, 1'b0, '0},
    '{20'h00400, 16'h2000, 1'b0, '0},
    '{20'h00400, 16'hE000, 1'b0, '0},
    '{20'h00001, 16'h0FFF, 1'b0, '0}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic signed [X_W-1:0] in_x_value = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [EXP_W-1:0]      out_exp_value;
  logic [TERMS_W-1:0]    out_terms_used;
  logic                  out_limit_hit;
  logic                  cfg_wr_en = 1'b0;
  logic [TOL_W-1:0]      cfg_wr_data = '0;

  exp_res_t pending_exp[$];
  exp_res_t want;
  logic [TOL_W-1:0] tol_model = TOL_RST;
  logic idle_en = 1'b1;
  int n_fail = 0;
  int quiet_cycles = 0;

  exp_taylor_series_core #(
    .MAX_TERMS(TERM_LIMIT)
  ) uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_x_value    (in_x_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_exp_value (out_exp_value),
    .out_terms_used(out_terms_used),
    .out_limit_hit (out_limit_hit),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // series sum with truncated sign-magnitude terms, stopping below tolerance
  function automatic exp_res_t series_exp(input logic [X_W-1:0] x,
                                          input logic [TOL_W-1:0] tol);
    logic           x_neg;
    logic           t_neg;
    logic           done;
    logic [X_W-1:0] x_pos;
    logic [63:0]    x_abs;
    logic [63:0]    mag;
    longint         acc;
    int             n;
    exp_res_t       r;
    x_neg = x[X_W-1];
    // magnitude taken at 16 bits, so -8.0 gives 0x8000
    x_pos = x_neg ? (~x + 1'b1) : x;
    x_abs = 64'(x_pos);
    mag = 64'd1 << 20;
    acc = longint'(mag);
    t_neg = 1'b0;
    done = 1'b0;
    n = 0;
    while (!done && n < TERM_LIMIT) begin
      n++;
      mag = (mag * x_abs) / (64'(n) * 64'd4096);
      t_neg = t_neg ^ x_neg;
      acc = t_neg ? acc - longint'(mag) : acc + longint'(mag);
      if (mag < 64'(tol))
        done = 1'b1;
    end
    if (acc < 0)
      r.exp_value = '0;
    else if (acc > longint'(64'hFFFF_FFFF))
      r.exp_value = '1;
    else
      r.exp_value = acc[EXP_W-1:0];
    r.terms_used = (n > 63) ? 6'd63 : 6'(n);
    r.limit_hit = !done;
    return r;
  endfunction

  task automatic issue_x(input logic [X_W-1:0] x, input logic typed,
                         input exp_res_t typed_res);
    while (idle_en && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_x_value <= x;
    pending_exp.push_back(typed ? typed_res : series_exp(x, tol_model));
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_exp.size() != 0) @(posedge clk);
  endtask

  task automatic set_tolerance(input logic [TOL_W-1:0] tol);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= tol;
    tol_model = tol;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  always @(posedge clk) begin
    out_ready <= idle_en ? ($urandom_range(99) >= 22) : 1'b1;
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_exp.size() == 0) begin
        n_fail++;
        if (n_fail <= 10)
          $display("unexpected item: exp %h terms %0d limit %0b",
                   out_exp_value, out_terms_used, out_limit_hit);
      end else begin
        want = pending_exp.pop_front();
        if (out_exp_value !== want.exp_value || out_terms_used !== want.terms_used ||
            out_limit_hit !== want.limit_hit) begin
          n_fail++;
          if (n_fail <= 10)
            $display("bad item: exp %h/%h terms %0d/%0d limit %0b/%0b (want/got)",
                     want.exp_value, out_exp_value, want.terms_used, out_terms_used,
                     want.limit_hit, out_limit_hit);
        end
      end
    end
  end

  // watchdog on cycles with no handshake on any port
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("exp_taylor_series_core: mismatch");
      $finish;
    end
  end

  initial begin
    int ph;
    int k;
    logic [X_W-1:0] xr;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (k = 0; k < N_DIR; k++) begin
      if (DIR_TAB[k].tol != tol_model)
        set_tolerance(DIR_TAB[k].tol);
      issue_x(DIR_TAB[k].x, DIR_TAB[k].typed, DIR_TAB[k].res);
    end

    for (ph = 0; ph < N_PHASE; ph++) begin
      case (ph)
        0: set_tolerance(TOL_RST);
        1: set_tolerance('0);
        2: set_tolerance('1);
        3: set_tolerance(TOL_W'($urandom_range(64, 2)));
        4: set_tolerance(TOL_W'($urandom));
        6: set_tolerance(TOL_W'($urandom_range(8192, 1)));
        default: set_tolerance(TOL_RST);
      endcase
      // one phase runs flat out on both channels
      idle_en = (ph != 5);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        case ($urandom_range(9))
          0, 1, 2, 3, 4: xr = X_W'($urandom);
          5, 6: xr = X_W'($urandom_range(8192) - 4096);
          7: xr = $urandom_range(1) ? 16'h7FFF - X_W'($urandom_range(255))
                                    : 16'h8000 + X_W'($urandom_range(255));
          8: xr = {4'($urandom), 12'h000};
          default: xr = X_W'($urandom_range(31)) - 16'd16;
        endcase
        issue_x(xr, 1'b0, '0);
      end
    end

    drain();
    repeat (200) @(posedge clk);
    if (pending_exp.size() != 0) begin
      n_fail += pending_exp.size();
      $display("results missing: %0d", pending_exp.size());
    end
    if (n_fail == 0)
      $display("exp_taylor_series_core: match");
    else
      $display("exp_taylor_series_core: mismatch");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/exp_ts_pkg.sv
rtl/core/exp_ts_recip.sv
rtl/core/exp_ts_mul.sv
rtl/core/exp_ts_seq.sv
rtl/core/exp_taylor_series_core.sv
sim/tb_exp_taylor_series_core.sv
